FILE: rtl/cdq_pkg.sv
// cdq_pkg: shared codes and controller/datapath interface types for the circular deque
// no dependencies; used by circular_deque, cdq_ctrl, cdq_dp and cdq_checker
package cdq_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;   // take the input transaction this cycle
    logic capture;  // load the store read data into the result register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;  // the offered item is a pop on a non-empty deque
  } dp_stat_t;

endpackage

FILE: rtl/circular_deque.sv
// circular_deque: double-ended queue of signed words in a circular store of DEPTH entries
// depends on cdq_pkg, cdq_ctrl, cdq_dp (and cdq_ram through the datapath)
//
// usage:
//   input channel (in_valid/in_ready) carries in_mode (push front, push back,
//   pop front, pop back) and in_push_value; every input transaction gives
//   exactly one output transaction (out_valid/out_ready) with out_popped_value
//   and out_status (ok, overflow, underflow).
//   a push result is offered in the cycle after acceptance; a successful pop
//   first passes through the read state, since the word comes through the
//   registered read port of the store. a failed push or pop changes nothing
//   and returns zero. one item is in flight at a time; a new item is taken in
//   the same cycle that the pending result is taken, so pushes and failed ops
//   stream at one per cycle while out_ready is high; no item is taken in the read state.
//   while out_ready is low the result holds and in_ready stays low.
//   reset (rst_n low, synchronous) empties the deque and drops any pending
//   result; store contents are not cleared and are never read before written.
module circular_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cdq_pkg::MODE_W-1:0]        in_mode,
  input  logic signed [cdq_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cdq_pkg::WORD_W-1:0] out_popped_value,
  output logic [cdq_pkg::STAT_W-1:0]        out_status
);

  cdq_pkg::dp_cmd_t  cmd;
  cdq_pkg::dp_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (in_mode),
    .push_value  (in_push_value),
    .popped_value(out_popped_value),
    .status      (out_status)
  );

endmodule

FILE: rtl/cdq_ram.sv
// cdq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/cdq_ctrl.sv
// cdq_ctrl: sequencing state machine for the circular deque
// depends on cdq_pkg for the command and status structs
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cdq_pkg::dp_stat_t stat,
  output cdq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_RESP) && out_ready);
  assign out_valid = (state_r == S_RESP);
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = accept;
    cmd.capture = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = stat.needs_read ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        cmd.capture = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (accept) begin
          state_nxt = stat.needs_read ? S_READ : S_RESP;
        end else if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/cdq_dp.sv
// cdq_dp: index registers, empty flag, word store and result registers
// depends on cdq_pkg and cdq_ram
module cdq_dp #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cdq_pkg::dp_cmd_t                cmd,
  output cdq_pkg::dp_stat_t               stat,
  input  logic [cdq_pkg::MODE_W-1:0]      mode,
  input  logic signed [cdq_pkg::WORD_W-1:0] push_value,
  output logic signed [cdq_pkg::WORD_W-1:0] popped_value,
  output logic [cdq_pkg::STAT_W-1:0]      status
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic             empty_r, empty_nxt;
  logic [cdq_pkg::WORD_W-1:0] popped_r, popped_nxt;
  logic [cdq_pkg::STAT_W-1:0] status_r, status_nxt;

  logic [IDX_W-1:0] front_prev, front_next, back_prev, back_next;
  logic             full;
  logic             is_pop;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [cdq_pkg::WORD_W-1:0] rdata;

  assign front_prev = (front_r == '0) ? LAST : front_r - 1'b1;
  assign front_next = (front_r == LAST) ? '0 : front_r + 1'b1;
  assign back_prev  = (back_r == '0) ? LAST : back_r - 1'b1;
  assign back_next  = (back_r == LAST) ? '0 : back_r + 1'b1;
  assign full       = !empty_r && (back_next == front_r);
  assign is_pop     = mode[1];

  assign stat.needs_read = is_pop && !empty_r;

  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    empty_nxt  = empty_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = '0;
    raddr      = (mode == cdq_pkg::MODE_POP_FRONT) ? front_r : back_r;
    if (cmd.accept) begin
      popped_nxt = '0;
      status_nxt = cdq_pkg::ST_OK;
      if (!is_pop) begin
        if (full) begin
          status_nxt = cdq_pkg::ST_OVERFLOW;
        end else begin
          we = 1'b1;
          if (empty_r) begin
            // first word always lands at entry zero
            front_nxt = '0;
            back_nxt  = '0;
            empty_nxt = 1'b0;
            waddr     = '0;
          end else if (mode == cdq_pkg::MODE_PUSH_FRONT) begin
            front_nxt = front_prev;
            waddr     = front_prev;
          end else begin
            back_nxt = back_next;
            waddr    = back_next;
          end
        end
      end else begin
        if (empty_r) begin
          status_nxt = cdq_pkg::ST_UNDERFLOW;
        end else begin
          re = 1'b1;
          if (front_r == back_r) begin
            empty_nxt = 1'b1;
            front_nxt = '0;
            back_nxt  = '0;
          end else if (mode == cdq_pkg::MODE_POP_FRONT) begin
            front_nxt = front_next;
          end else begin
            back_nxt = back_prev;
          end
        end
      end
    end
    if (cmd.capture) begin
      popped_nxt = rdata;
    end
  end

  cdq_ram #(
    .WIDTH(cdq_pkg::WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(push_value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  assign popped_value = popped_r;
  assign status       = status_r;

endmodule

FILE: rtl/cdq_checker.sv
// cdq_checker: port-level assertions for circular_deque, attached with bind
// depends on cdq_pkg for status codes and field widths
module cdq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [cdq_pkg::MODE_W-1:0]        in_mode,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [cdq_pkg::WORD_W-1:0] out_popped_value,
  input logic [cdq_pkg::STAT_W-1:0]        out_status
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_value) && $stable(out_status))
    else $error("result changed while stalled");

  // failed transactions return zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != cdq_pkg::ST_OK |-> out_popped_value == '0)
    else $error("nonzero word on failed transaction");

  // a push never reports underflow
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode[1] |=>
      !(out_valid && out_status == cdq_pkg::ST_UNDERFLOW))
    else $error("underflow reported for a push");

  // no new item is taken while a result waits unclaimed
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // reset drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);
